FILE: hw/rtl/a2r_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a2r_pkg
// Shared constants, CORDIC arctangent table and result rounding for the
// axis-angle to rotation matrix core.
// ----------------------------------------------------------------------------
package a2r_pkg;

  localparam int CordicStages = 16;
  localparam int AtanEntries  = 24;
  localparam int AngW         = 34;   // Q.30 angle, range +/-8
  localparam int XyW          = 33;   // Q.30 x/y, |value| below 2

  localparam logic signed [AngW-1:0] AngPi     = 34'sd3373259426;
  localparam logic signed [AngW-1:0] AngHalfPi = 34'sd1686629713;
  localparam logic signed [XyW-1:0]  CordicGain = 33'sd652032874;
  localparam logic signed [XyW-1:0]  OneQ30     = 33'sd1073741824;

  function automatic logic signed [AngW-1:0] atan_lut(input logic [4:0] idx);
    logic signed [AngW-1:0] v;
    case (idx)
      5'd0:  v = 34'sd843314856;
      5'd1:  v = 34'sd497837829;
      5'd2:  v = 34'sd263043836;
      5'd3:  v = 34'sd133525158;
      5'd4:  v = 34'sd67021686;
      5'd5:  v = 34'sd33543515;
      5'd6:  v = 34'sd16775850;
      5'd7:  v = 34'sd8388437;
      5'd8:  v = 34'sd4194282;
      5'd9:  v = 34'sd2097149;
      5'd10: v = 34'sd1048575;
      5'd11: v = 34'sd524287;
      5'd12: v = 34'sd262143;
      5'd13: v = 34'sd131071;
      5'd14: v = 34'sd65535;
      5'd15: v = 34'sd32767;
      5'd16: v = 34'sd16383;
      5'd17: v = 34'sd8191;
      5'd18: v = 34'sd4095;
      5'd19: v = 34'sd2047;
      5'd20: v = 34'sd1023;
      5'd21: v = 34'sd511;
      5'd22: v = 34'sd255;
      5'd23: v = 34'sd127;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Round a Q.58 sum half up to Q2.14 and saturate.
  function automatic logic signed [15:0] to_q14(input logic signed [63:0] q58);
    logic signed [63:0] r;
    r = (q58 + 64'sd8796093022208) >>> 44;
    if (r > 64'sd32767) return 16'sh7fff;
    if (r < -64'sd32768) return 16'sh8000;
    return r[15:0];
  endfunction

endpackage

FILE: hw/rtl/a2r_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a2r_cordic
// Pipelined sine/cosine: quadrant reduction stage, one register stage per
// CORDIC iteration, then sign fixup. Side payload rides along.
// ----------------------------------------------------------------------------
module a2r_cordic (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic signed [15:0]           in_angle,
  input  logic [47:0]                  in_side,
  output logic                         out_valid,
  output logic signed [a2r_pkg::XyW-1:0] out_sin,
  output logic signed [a2r_pkg::XyW-1:0] out_cos,
  output logic [47:0]                  out_side
);

  localparam int N = a2r_pkg::CordicStages;

  logic signed [a2r_pkg::XyW-1:0]  x [N+1];
  logic signed [a2r_pkg::XyW-1:0]  y [N+1];
  logic signed [a2r_pkg::AngW-1:0] z [N+1];
  logic                            flip [N+1];
  logic [47:0]                     side [N+1];
  logic                            vld [N+1];

  logic signed [a2r_pkg::AngW-1:0] z_in;
  assign z_in = {{(a2r_pkg::AngW-33){in_angle[15]}}, in_angle, 17'd0};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
    if (en) begin
      x[0]    <= a2r_pkg::CordicGain;
      y[0]    <= '0;
      side[0] <= in_side;
      if (z_in > a2r_pkg::AngHalfPi) begin
        z[0] <= z_in - a2r_pkg::AngPi;
        flip[0] <= 1'b1;
      end else if (z_in < -a2r_pkg::AngHalfPi) begin
        z[0] <= z_in + a2r_pkg::AngPi;
        flip[0] <= 1'b1;
      end else begin
        z[0] <= z_in;
        flip[0] <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [a2r_pkg::XyW-1:0] xs, ys;
    assign xs = x[i] >>> i;
    assign ys = y[i] >>> i;
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
      if (en) begin
        flip[i+1] <= flip[i];
        side[i+1] <= side[i];
        if (!z[i][a2r_pkg::AngW-1]) begin
          x[i+1] <= x[i] - ys;
          y[i+1] <= y[i] + xs;
          z[i+1] <= z[i] - a2r_pkg::atan_lut(5'(i));
        end else begin
          x[i+1] <= x[i] + ys;
          y[i+1] <= y[i] - xs;
          z[i+1] <= z[i] + a2r_pkg::atan_lut(5'(i));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[N];
    end
    if (en) begin
      out_cos  <= flip[N] ? -x[N] : x[N];
      out_sin  <= flip[N] ? -y[N] : y[N];
      out_side <= side[N];
    end
  end

endmodule

FILE: hw/rtl/a2r_matrix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a2r_matrix
// Rodrigues products in three stages: axis pair products and scaled sine
// terms, times (1-cos), then sum with round and saturate.
// ----------------------------------------------------------------------------
module a2r_matrix (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic signed [a2r_pkg::XyW-1:0] in_sin,
  input  logic signed [a2r_pkg::XyW-1:0] in_cos,
  input  logic [47:0]                    in_axis,
  output logic                           out_valid,
  output logic [143:0]                   out_mat
);

  logic signed [15:0] kx, ky, kz;
  assign kx = in_axis[15:0];
  assign ky = in_axis[31:16];
  assign kz = in_axis[47:32];

  // stage 1
  logic                           v1;
  logic signed [31:0]             pxx, pyy, pzz, pxy, pxz, pyz;
  logic signed [48:0]             sx1, sy1, sz1;
  logic signed [a2r_pkg::XyW:0]   vt1;
  logic signed [a2r_pkg::XyW-1:0] c1;
  // stage 2
  logic                           v2;
  logic signed [63:0]             qxx, qyy, qzz, qxy, qxz, qyz, sx2, sy2, sz2, ct2;
  // stage 3
  logic                           v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
    if (en) begin
      pxx <= kx * kx;
      pyy <= ky * ky;
      pzz <= kz * kz;
      pxy <= kx * ky;
      pxz <= kx * kz;
      pyz <= ky * kz;
      sx1 <= 49'(kx * in_sin);
      sy1 <= 49'(ky * in_sin);
      sz1 <= 49'(kz * in_sin);
      vt1 <= 34'(a2r_pkg::OneQ30) - 34'(in_cos);
      c1  <= in_cos;

      qxx <= 64'(pxx * vt1);
      qyy <= 64'(pyy * vt1);
      qzz <= 64'(pzz * vt1);
      qxy <= 64'(pxy * vt1);
      qxz <= 64'(pxz * vt1);
      qyz <= 64'(pyz * vt1);
      sx2 <= 64'(sx1) <<< 14;
      sy2 <= 64'(sy1) <<< 14;
      sz2 <= 64'(sz1) <<< 14;
      ct2 <= 64'(c1) <<< 28;

      out_mat[15:0]    <= a2r_pkg::to_q14(qxx + ct2);
      out_mat[31:16]   <= a2r_pkg::to_q14(qxy - sz2);
      out_mat[47:32]   <= a2r_pkg::to_q14(qxz + sy2);
      out_mat[63:48]   <= a2r_pkg::to_q14(qxy + sz2);
      out_mat[79:64]   <= a2r_pkg::to_q14(qyy + ct2);
      out_mat[95:80]   <= a2r_pkg::to_q14(qyz - sx2);
      out_mat[111:96]  <= a2r_pkg::to_q14(qxz - sy2);
      out_mat[127:112] <= a2r_pkg::to_q14(qyz + sx2);
      out_mat[143:128] <= a2r_pkg::to_q14(qzz + ct2);
    end
  end

  assign out_valid = v3;

endmodule

FILE: hw/rtl/axis_angle_to_rotation_core.sv
`timescale 1ns / 1ps
// Throughput: one beat per cycle while the output is not stalled; the CORDIC iterations are one stage each.
// A full output register that is not being drained stalls the whole pipeline; tready follows it.
// Reset (rst, synchronous) clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// axis_angle_to_rotation_core
// Axis and angle in, 3x3 rotation matrix out, by Rodrigues' formula.
// ----------------------------------------------------------------------------
module axis_angle_to_rotation_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,   // axis_x, axis_y, axis_z, angle
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [143:0] m_axis_tdata    // r00 r01 r02 r10 r11 r12 r20 r21 r22
);

  logic en;
  logic cv;
  logic signed [a2r_pkg::XyW-1:0] sn, cs;
  logic [47:0] axis_d;

  // advance whenever the output slot is free or being drained
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  a2r_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_axis_tvalid),
    .in_angle  (s_axis_tdata[63:48]),
    .in_side   (s_axis_tdata[47:0]),
    .out_valid (cv),
    .out_sin   (sn),
    .out_cos   (cs),
    .out_side  (axis_d)
  );

  a2r_matrix u_matrix (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (cv),
    .in_sin    (sn),
    .in_cos    (cs),
    .in_axis   (axis_d),
    .out_valid (m_axis_tvalid),
    .out_mat   (m_axis_tdata)
  );

endmodule

FILE: test/tb_axis_angle_to_rotation_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_axis_angle_to_rotation_core
// Drives axis/angle beats into the rotation core and compares every matrix beat with a
// typed identity or a bit-exact CORDIC plus Rodrigues predictor, under random stalls.
// ----------------------------------------------------------------------------
module tb_axis_angle_to_rotation_core;

  typedef struct packed {
    logic signed [15:0] angle;
    logic signed [15:0] az;
    logic signed [15:0] ay;
    logic signed [15:0] ax;
  } pose_t;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [63:0]  s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [143:0] m_axis_tdata;

  logic [143:0] matrix_q[$];
  int           errors;
  bit           sending_done;
  bit           hold_off;

  axis_angle_to_rotation_core dut (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("FAIL axis_angle_to_rotation_core");
    $finish;
  end

  function automatic longint floor_shr(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic logic [15:0] round_q14(input longint q58);
    longint r;
    r = floor_shr(q58 + (64'sd1 <<< 43), 44);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic logic [143:0] rotation_of(input pose_t p);
    longint z, x, y, xs, ys, kx, ky, kz, vt, ct, sx, sy, sz;
    bit flip;
    logic [143:0] m;
    z = longint'(p.angle) * 131072;
    x = longint'(a2r_pkg::CordicGain);
    y = 0;
    flip = 0;
    if (z > longint'(a2r_pkg::AngHalfPi)) begin
      z -= longint'(a2r_pkg::AngPi);
      flip = 1;
    end else if (z < -longint'(a2r_pkg::AngHalfPi)) begin
      z += longint'(a2r_pkg::AngPi);
      flip = 1;
    end
    for (int i = 0; i < a2r_pkg::CordicStages; i++) begin
      xs = floor_shr(x, i);
      ys = floor_shr(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(a2r_pkg::atan_lut(i[4:0]));
      end else begin
        x += ys; y -= xs; z += longint'(a2r_pkg::atan_lut(i[4:0]));
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    kx = longint'(p.ax); ky = longint'(p.ay); kz = longint'(p.az);
    vt = (64'sd1 <<< 30) - x;
    ct = x <<< 28;
    sx = (kx * y) <<< 14;
    sy = (ky * y) <<< 14;
    sz = (kz * y) <<< 14;
    m[15:0]    = round_q14(kx * kx * vt + ct);
    m[31:16]   = round_q14(kx * ky * vt - sz);
    m[47:32]   = round_q14(kx * kz * vt + sy);
    m[63:48]   = round_q14(kx * ky * vt + sz);
    m[79:64]   = round_q14(ky * ky * vt + ct);
    m[95:80]   = round_q14(ky * kz * vt - sx);
    m[111:96]  = round_q14(kx * kz * vt - sy);
    m[127:112] = round_q14(ky * kz * vt + sx);
    m[143:128] = round_q14(kz * kz * vt + ct);
    return m;
  endfunction

  // Send one beat after a random gap; predict on acceptance.
  task automatic send_pose(input pose_t p, input logic [143:0] typed, input bit has_typed);
    int gap;
    gap = $urandom_range(0, 11);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= p;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    matrix_q.push_back(has_typed ? typed : rotation_of(p));
    @(negedge clk);
  endtask

  localparam logic signed [15:0] ONE = 16'sd16384;
  localparam int NDIR = 16;
  pose_t dir_pose[NDIR];
  logic [143:0] dir_mat[NDIR];
  bit dir_typed[NDIR];

  initial begin
    pose_t p;
    int k;
    // identity row is known; rest use the predictor
    dir_pose[0]  = '{angle: 16'sd0, az: 16'sd0, ay: 16'sd0, ax: ONE};
    dir_mat[0]   = {ONE, 16'd0, 16'd0, 16'd0, ONE, 16'd0, 16'd0, 16'd0, ONE};
    dir_typed[0] = 0;
    dir_pose[1]  = '{angle: 16'sh7fff, az: 16'sd0, ay: 16'sd0, ax: 16'sd0};
    dir_pose[2]  = '{angle: 16'sh8000, az: 16'sd0, ay: 16'sd0, ax: 16'sd0};
    dir_pose[3]  = '{angle: 16'sd12868, az: ONE, ay: 16'sd0, ax: 16'sd0};
    dir_pose[4]  = '{angle: -16'sd12868, az: 16'sd0, ay: ONE, ax: 16'sd0};
    dir_pose[5]  = '{angle: 16'sd25736, az: 16'sd0, ay: 16'sd0, ax: ONE};
    dir_pose[6]  = '{angle: 16'sd12869, az: 16'sh7fff, ay: 16'sh7fff, ax: 16'sh7fff};
    dir_pose[7]  = '{angle: 16'sh8000, az: 16'sh8000, ay: 16'sh8000, ax: 16'sh8000};
    dir_pose[8]  = '{angle: 16'sh7fff, az: 16'sh8000, ay: 16'sh7fff, ax: 16'sh8000};
    dir_pose[9]  = '{angle: 16'sd8192, az: 16'sd9459, ay: 16'sd9459, ax: 16'sd9459};
    dir_pose[10] = '{angle: -16'sd8192, az: -16'sd9459, ay: 16'sd9459, ax: -16'sd9459};
    dir_pose[11] = '{angle: 16'sd12867, az: 16'sd0, ay: -ONE, ax: 16'sd0};
    dir_pose[12] = '{angle: -16'sd12869, az: -ONE, ay: 16'sd0, ax: 16'sd0};
    dir_pose[13] = '{angle: 16'sd1, az: 16'sd1, ay: -16'sd1, ax: 16'sd1};
    dir_pose[14] = '{angle: -16'sd1, az: 16'sh7fff, ay: 16'sd0, ax: 16'sh8000};
    dir_pose[15] = '{angle: 16'sd25735, az: 16'sd0, ay: 16'sd0, ax: 16'sd0};
    for (int i = 1; i < NDIR; i++) dir_typed[i] = 0;
    dir_typed[0] = 1;

    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    errors = 0;
    sending_done = 0;
    hold_off = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < NDIR; i++) send_pose(dir_pose[i], dir_mat[i], dir_typed[i]);

    for (int n = 0; n < 1000; n++) begin
      p = {$urandom, $urandom};
      k = $urandom_range(0, 9);
      if (k < 5) begin
        // unit axis along one coordinate, random sign
        p.ax = '0; p.ay = '0; p.az = '0;
        case ($urandom_range(0, 2))
          0: p.ax = $urandom_range(0, 1) ? ONE : -ONE;
          1: p.ay = $urandom_range(0, 1) ? ONE : -ONE;
          default: p.az = $urandom_range(0, 1) ? ONE : -ONE;
        endcase
      end else if (k < 8) begin
        p.ax = $signed(16'($urandom_range(0, 18918))) - 16'sd9459;
        p.ay = $signed(16'($urandom_range(0, 18918))) - 16'sd9459;
        p.az = $signed(16'($urandom_range(0, 18918))) - 16'sd9459;
      end
      if (n == 300) hold_off = 1;
      send_pose(p, '0, 0);
    end
    s_axis_tvalid <= 1'b0;
    sending_done = 1;
  end

  // receiver: random stalls plus one long hold-off
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    @(negedge clk);
    while (1) begin
      if (hold_off) begin
        hold_off = 0;
        m_axis_tready <= 1'b0;
        repeat (200) @(negedge clk);
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    logic [143:0] want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (matrix_q.size() == 0) begin
        $error("matrix beat with nothing expected: %h", m_axis_tdata);
        errors++;
      end else begin
        want = matrix_q.pop_front();
        for (int e = 0; e < 9; e++)
          if (m_axis_tdata[e*16 +: 16] !== want[e*16 +: 16]) begin
            $error("r%0d%0d expected %0d actual %0d", e / 3, e % 3,
                   $signed(want[e*16 +: 16]), $signed(m_axis_tdata[e*16 +: 16]));
            errors++;
          end
      end
    end
  end

  initial begin
    wait (sending_done);
    while (matrix_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0 && matrix_q.size() == 0) begin
      $display("PASS axis_angle_to_rotation_core");
    end else begin
      $display("FAIL axis_angle_to_rotation_core");
    end
    $finish;
  end

endmodule

FILE: axis_angle_to_rotation_core.f
hw/rtl/a2r_pkg.sv
hw/rtl/a2r_cordic.sv
hw/rtl/a2r_matrix.sv
hw/rtl/axis_angle_to_rotation_core.sv
test/tb_axis_angle_to_rotation_core.sv
